// ===== hdl/fuba_pkg.sv =====
// Shared types and constants for the frame upload buffer allocator.
`default_nettype none
package fuba_pkg;

  localparam int POOL_ENTRIES = 8;
  localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;

  localparam int CAP_W = 31;
  localparam int FRAME_W = 32;
  localparam int FIF_W = 4;
  localparam int ALOG_W = 5;
  localparam int BIDX_W = 3;
  localparam int ALU_W = 34;

  localparam logic [ALOG_W-1:0] MIN_ALIGN_LOG2 = 5'd4;
  localparam logic [31:0] MIB_MASK = 32'h000F_FFFF;
  localparam logic [CAP_W-1:0] CAP_MASK = 31'h7FFF_FFFF;

  localparam logic [FIF_W-1:0] FIF_RESET = 4'd2;
  localparam logic [CAP_W-1:0] MIN_BYTES_RESET = 31'd4194304;

  localparam logic [1:0] CFG_FRAMES_IN_FLIGHT = 2'd0;
  localparam logic [1:0] CFG_MIN_BUFFER_BYTES = 2'd1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_MARK = 1'b1;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MARK,
    ST_AGE,
    ST_ROUND,
    ST_FIT,
    ST_CAP,
    ST_MIN,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               present;
    logic               available;
    logic [FRAME_W-1:0] last_frame;
    logic [CAP_W-1:0]   capacity;
    logic [CAP_W-1:0]   fill;
  } entry_t;

  typedef struct packed {
    logic               mark;
    logic               cap_we;
    logic               fill_we;
    logic [IDX_W-1:0]   idx;
    logic [CAP_W-1:0]   capacity;
    logic [CAP_W-1:0]   fill;
    logic [FRAME_W-1:0] last_frame;
  } pool_wr_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [ALU_W-1:0] c;
  } alu_op_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             le;
  } alu_res_t;

  typedef struct packed {
    logic              status;
    logic [BIDX_W-1:0] buffer_index;
    logic [CAP_W-1:0]  byte_offset;
    logic              newly_created;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/frame_upload_buffer_allocator.sv =====
// Top level: configuration registers, sequencer, pool, shared adder and result register.
//
// One item is in work at a time; in_ready is high only while the block is idle. A mark
// item passes through accept, MARK and DONE. An allocate item scans the pool in order
// through one shared 34-bit adder/comparator: AGE alone for an absent or unusable entry,
// AGE and FIT for an entry that may be reused, AGE, ROUND and FIT for one already used
// this frame, then FILL to write the chosen entry, or CAP, MIN and FILL to create a new
// one, and DONE to hand the result to the output register. A finished result waits in
// DONE while the output register holds a result not yet taken; the shared adder and the
// single pool read port set the pace. The result register lets the next item be
// accepted while the previous result waits to be taken.
`default_nettype none
module frame_upload_buffer_allocator (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_write,
  input  wire [1:0]                    cfg_index,
  input  wire [fuba_pkg::CAP_W-1:0]    cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          mode,
  input  wire [fuba_pkg::FRAME_W-1:0]  frame_number,
  input  wire [fuba_pkg::CAP_W-1:0]    request_bytes,
  input  wire [fuba_pkg::ALOG_W-1:0]   align_log2,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         status,
  output logic [fuba_pkg::BIDX_W-1:0]  buffer_index,
  output logic [fuba_pkg::CAP_W-1:0]   byte_offset,
  output logic                         newly_created
);

  logic [fuba_pkg::FIF_W-1:0]  frames_in_flight;
  logic [fuba_pkg::CAP_W-1:0]  min_buffer_bytes;

  logic                        out_free;
  logic                        done;
  fuba_pkg::result_t           result;
  logic [fuba_pkg::IDX_W-1:0]  rd_idx;
  fuba_pkg::entry_t            ent;
  fuba_pkg::pool_wr_t          wr;
  fuba_pkg::alu_op_t           alu_op;
  fuba_pkg::alu_res_t          alu_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_flight <= fuba_pkg::FIF_RESET;
      min_buffer_bytes <= fuba_pkg::MIN_BYTES_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fuba_pkg::CFG_FRAMES_IN_FLIGHT: frames_in_flight <= cfg_data[fuba_pkg::FIF_W-1:0];
        fuba_pkg::CFG_MIN_BUFFER_BYTES: min_buffer_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  fuba_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .mode             (mode),
    .frame_number     (frame_number),
    .request_bytes    (request_bytes),
    .align_log2       (align_log2),
    .frames_in_flight (frames_in_flight),
    .min_buffer_bytes (min_buffer_bytes),
    .out_free         (out_free),
    .done             (done),
    .result           (result),
    .rd_idx           (rd_idx),
    .ent              (ent),
    .wr               (wr),
    .alu_op           (alu_op),
    .alu_res          (alu_res)
  );

  fuba_pool u_pool (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (rd_idx),
    .rd_entry (ent),
    .wr       (wr)
  );

  fuba_alu u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      status <= result.status;
      buffer_index <= result.buffer_index;
      byte_offset <= result.byte_offset;
      newly_created <= result.newly_created;
    end
  end

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item while busy");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !newly_created && buffer_index == '0 && byte_offset == '0)
    else $error("pool-full result carries buffer data");

  a_created_at_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && newly_created |-> byte_offset == '0 && !status)
    else $error("new buffer not served at offset zero");

  a_pool_write_excl: assert property (@(posedge clk) disable iff (rst)
    $countones({wr.mark, wr.cap_we, wr.fill_we}) <= 1)
    else $error("overlapping pool writes");

endmodule
`default_nettype wire

// ===== hdl/fuba_alu.sv =====
// Shared adder and compare unit: sum = a + b, le = (a + b <= c).
`default_nettype none
module fuba_alu (
  input  fuba_pkg::alu_op_t  op,
  output fuba_pkg::alu_res_t res
);

  always_comb begin
    res.sum = op.a + op.b;
    res.le = (res.sum <= op.c);
  end

endmodule
`default_nettype wire

// ===== hdl/fuba_pool.sv =====
// Buffer pool state: presence, availability, last frame, capacity and fill per entry.
`default_nettype none
module fuba_pool (
  input  wire                          clk,
  input  wire                          rst,
  input  wire [fuba_pkg::IDX_W-1:0]    rd_idx,
  output fuba_pkg::entry_t             rd_entry,
  input  fuba_pkg::pool_wr_t           wr
);

  logic [fuba_pkg::POOL_ENTRIES-1:0] present;
  logic [fuba_pkg::POOL_ENTRIES-1:0] available;
  logic [fuba_pkg::FRAME_W-1:0]      last_frame [fuba_pkg::POOL_ENTRIES];
  logic [fuba_pkg::CAP_W-1:0]        capacity [fuba_pkg::POOL_ENTRIES];
  logic [fuba_pkg::CAP_W-1:0]        fill [fuba_pkg::POOL_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      available <= '0;
    end else begin
      if (wr.mark) begin
        available <= available | present;
      end
      if (wr.cap_we) begin
        present[wr.idx] <= 1'b1;
      end
      if (wr.fill_we) begin
        available[wr.idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.cap_we) begin
      capacity[wr.idx] <= wr.capacity;
    end
    if (wr.fill_we) begin
      fill[wr.idx] <= wr.fill;
      last_frame[wr.idx] <= wr.last_frame;
    end
  end

  always_comb begin
    rd_entry.present = present[rd_idx];
    rd_entry.available = available[rd_idx];
    rd_entry.last_frame = last_frame[rd_idx];
    rd_entry.capacity = capacity[rd_idx];
    rd_entry.fill = fill[rd_idx];
  end

endmodule
`default_nettype wire

// ===== hdl/fuba_ctrl.sv =====
// Sequencer: scans the pool one entry at a time and drives the shared adder.
`default_nettype none
module fuba_ctrl (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire                           mode,
  input  wire [fuba_pkg::FRAME_W-1:0]   frame_number,
  input  wire [fuba_pkg::CAP_W-1:0]     request_bytes,
  input  wire [fuba_pkg::ALOG_W-1:0]    align_log2,
  input  wire [fuba_pkg::FIF_W-1:0]     frames_in_flight,
  input  wire [fuba_pkg::CAP_W-1:0]     min_buffer_bytes,
  input  wire                           out_free,
  output logic                          done,
  output fuba_pkg::result_t             result,
  output logic [fuba_pkg::IDX_W-1:0]    rd_idx,
  input  fuba_pkg::entry_t              ent,
  output fuba_pkg::pool_wr_t            wr,
  output fuba_pkg::alu_op_t             alu_op,
  input  fuba_pkg::alu_res_t            alu_res
);

  localparam logic [fuba_pkg::IDX_W-1:0] LAST_IDX =
    fuba_pkg::IDX_W'(fuba_pkg::POOL_ENTRIES - 1);

  fuba_pkg::state_t state, state_next;

  logic                          mode_r;
  logic [fuba_pkg::FRAME_W-1:0]  frame_r;
  logic [fuba_pkg::CAP_W-1:0]    size_r;
  logic [fuba_pkg::CAP_W-1:0]    mask_r;
  logic [fuba_pkg::IDX_W-1:0]    idx;
  logic                          free_found;
  logic [fuba_pkg::IDX_W-1:0]    free_idx;
  logic                          same_r;
  logic [31:0]                   rnd;
  logic [31:0]                   capr;
  logic                          res_status;
  logic                          res_created;
  logic [fuba_pkg::CAP_W-1:0]    res_offset;
  logic [fuba_pkg::IDX_W-1:0]    res_idx;

  logic [fuba_pkg::ALOG_W-1:0]   alog_clamped;
  logic                          same;
  logic                          is_last;
  logic                          go_round;
  logic                          go_fit;
  logic                          age_adv;
  logic                          fit_adv;
  logic                          scan_free;
  logic                          scan_end;
  logic [31:0]                   capm;
  logic [fuba_pkg::CAP_W-1:0]    cap_final;

  assign alog_clamped = (align_log2 < fuba_pkg::MIN_ALIGN_LOG2) ?
                        fuba_pkg::MIN_ALIGN_LOG2 : align_log2;

  always_comb begin
    same = ent.present && !ent.available && (ent.last_frame == frame_r);
    is_last = (idx == LAST_IDX);
    go_round = ent.present && same;
    go_fit = ent.present && !same && (ent.available || alu_res.le);
    age_adv = !go_round && !go_fit;
    fit_adv = !alu_res.le;
    scan_free = free_found || ((state == fuba_pkg::ST_AGE) && !ent.present);
    scan_end = is_last && (((state == fuba_pkg::ST_AGE) && age_adv) ||
                           ((state == fuba_pkg::ST_FIT) && fit_adv));
    capm = alu_res.le ? capr : {1'b0, min_buffer_bytes};
    cap_final = capm[31] ? fuba_pkg::CAP_MASK : capm[fuba_pkg::CAP_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fuba_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (mode == fuba_pkg::MODE_MARK) ? fuba_pkg::ST_MARK : fuba_pkg::ST_AGE;
        end
      end
      fuba_pkg::ST_MARK: state_next = fuba_pkg::ST_DONE;
      fuba_pkg::ST_AGE: begin
        if (go_round) begin
          state_next = fuba_pkg::ST_ROUND;
        end else if (go_fit) begin
          state_next = fuba_pkg::ST_FIT;
        end else if (is_last) begin
          state_next = scan_free ? fuba_pkg::ST_CAP : fuba_pkg::ST_DONE;
        end
      end
      fuba_pkg::ST_ROUND: state_next = fuba_pkg::ST_FIT;
      fuba_pkg::ST_FIT: begin
        if (!fit_adv) begin
          state_next = fuba_pkg::ST_FILL;
        end else if (is_last) begin
          state_next = scan_free ? fuba_pkg::ST_CAP : fuba_pkg::ST_DONE;
        end else begin
          state_next = fuba_pkg::ST_AGE;
        end
      end
      fuba_pkg::ST_CAP: state_next = fuba_pkg::ST_MIN;
      fuba_pkg::ST_MIN: state_next = fuba_pkg::ST_FILL;
      fuba_pkg::ST_FILL: state_next = fuba_pkg::ST_DONE;
      fuba_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = fuba_pkg::ST_IDLE;
        end
      end
      default: state_next = fuba_pkg::ST_IDLE;
    endcase
  end

  // outputs: adder operands and pool writes
  always_comb begin
    alu_op = '0;
    wr = '0;
    wr.idx = idx;
    wr.capacity = cap_final;
    wr.fill = alu_res.sum[fuba_pkg::CAP_W-1:0];
    wr.last_frame = frame_r;
    in_ready = 1'b0;
    done = 1'b0;
    unique case (state)
      fuba_pkg::ST_IDLE: in_ready = 1'b1;
      fuba_pkg::ST_MARK: wr.mark = 1'b1;
      fuba_pkg::ST_AGE: begin
        alu_op.a = fuba_pkg::ALU_W'(ent.last_frame);
        alu_op.b = fuba_pkg::ALU_W'(frames_in_flight);
        alu_op.c = fuba_pkg::ALU_W'(frame_r);
      end
      fuba_pkg::ST_ROUND: begin
        alu_op.a = fuba_pkg::ALU_W'(ent.fill);
        alu_op.b = fuba_pkg::ALU_W'(mask_r);
      end
      fuba_pkg::ST_FIT: begin
        alu_op.a = same_r ? fuba_pkg::ALU_W'(rnd) : '0;
        alu_op.b = fuba_pkg::ALU_W'(size_r);
        alu_op.c = fuba_pkg::ALU_W'(ent.capacity);
      end
      fuba_pkg::ST_CAP: begin
        alu_op.a = fuba_pkg::ALU_W'(size_r);
        alu_op.b = fuba_pkg::ALU_W'(fuba_pkg::MIB_MASK);
      end
      fuba_pkg::ST_MIN: begin
        // le means min <= rounded size
        alu_op.a = fuba_pkg::ALU_W'(min_buffer_bytes);
        alu_op.c = fuba_pkg::ALU_W'(capr);
        wr.cap_we = 1'b1;
      end
      fuba_pkg::ST_FILL: begin
        alu_op.a = fuba_pkg::ALU_W'(res_offset);
        alu_op.b = fuba_pkg::ALU_W'(size_r);
        wr.fill_we = 1'b1;
      end
      fuba_pkg::ST_DONE: done = 1'b1;
      default: ;
    endcase
  end

  assign rd_idx = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fuba_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_found <= 1'b0;
      res_status <= fuba_pkg::STATUS_OK;
      res_created <= 1'b0;
    end else begin
      if ((state == fuba_pkg::ST_IDLE) && in_valid) begin
        free_found <= 1'b0;
        res_status <= fuba_pkg::STATUS_OK;
        res_created <= 1'b0;
      end
      if ((state == fuba_pkg::ST_AGE) && !ent.present) begin
        free_found <= 1'b1;
      end
      if (scan_end && !scan_free) begin
        res_status <= fuba_pkg::STATUS_FULL;
      end
      if (state == fuba_pkg::ST_MIN) begin
        res_created <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      fuba_pkg::ST_IDLE: begin
        if (in_valid) begin
          mode_r <= mode;
          frame_r <= frame_number;
          size_r <= request_bytes;
          mask_r <= (fuba_pkg::CAP_W'(1) << alog_clamped) - fuba_pkg::CAP_W'(1);
          idx <= '0;
          res_offset <= '0;
          res_idx <= '0;
        end
      end
      fuba_pkg::ST_AGE: begin
        same_r <= same;
        if (!ent.present && !free_found) begin
          free_idx <= idx;
        end
        if (age_adv && !is_last) begin
          idx <= idx + fuba_pkg::IDX_W'(1);
        end
      end
      fuba_pkg::ST_ROUND: begin
        rnd <= alu_res.sum[31:0] & ~{1'b0, mask_r};
      end
      fuba_pkg::ST_FIT: begin
        if (!fit_adv) begin
          res_offset <= alu_op.a[fuba_pkg::CAP_W-1:0];
          res_idx <= idx;
        end else if (!is_last) begin
          idx <= idx + fuba_pkg::IDX_W'(1);
        end
      end
      fuba_pkg::ST_CAP: begin
        capr <= alu_res.sum[31:0] & ~fuba_pkg::MIB_MASK;
        // point the pool at the free slot before the capacity write
        idx <= free_idx;
      end
      fuba_pkg::ST_MIN: begin
        res_idx <= free_idx;
        res_offset <= '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    result.status = res_status;
    result.newly_created = res_created;
    result.byte_offset = (res_status == fuba_pkg::STATUS_FULL || mode_r == fuba_pkg::MODE_MARK) ?
                         '0 : res_offset;
    result.buffer_index = (res_status == fuba_pkg::STATUS_FULL || mode_r == fuba_pkg::MODE_MARK) ?
                          '0 : fuba_pkg::BIDX_W'(res_idx);
  end

endmodule
`default_nettype wire

// ===== tb/pool_grant_checker.sv =====
// Checker for the upload buffer allocator: predicts each grant and compares it with the block.
`timescale 1ns / 100ps
module pool_grant_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [fuba_pkg::CAP_W-1:0]   cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         mode,
  input  logic [fuba_pkg::FRAME_W-1:0] frame_number,
  input  logic [fuba_pkg::CAP_W-1:0]   request_bytes,
  input  logic [fuba_pkg::ALOG_W-1:0]  align_log2,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         status,
  input  logic [fuba_pkg::BIDX_W-1:0]  buffer_index,
  input  logic [fuba_pkg::CAP_W-1:0]   byte_offset,
  input  logic                         newly_created,
  output int                           fail_count,
  output int                           open_grants,
  output int                           full_count,
  output int                           new_count
);
  import fuba_pkg::*;

  localparam logic [63:0] MIB = 64'd1 << 20;

  logic               ent_present [POOL_ENTRIES];
  logic               ent_avail   [POOL_ENTRIES];
  logic [FRAME_W-1:0] ent_frame   [POOL_ENTRIES];
  logic [CAP_W-1:0]   ent_cap     [POOL_ENTRIES];
  logic [CAP_W-1:0]   ent_fill    [POOL_ENTRIES];
  logic [FIF_W-1:0]   fif_q;
  logic [CAP_W-1:0]   min_bytes_q;

  result_t grant_q[$];

  function automatic logic [63:0] round_to(input logic [63:0] v, input logic [63:0] a);
    return (v + a - 64'd1) & ~(a - 64'd1);
  endfunction

  // Applies one item to the local pool copy and returns the grant it should produce.
  task automatic serve_item(input logic m, input logic [FRAME_W-1:0] fr,
                            input logic [CAP_W-1:0] sz, input logic [ALOG_W-1:0] al,
                            output result_t r);
    logic [63:0] step;
    logic [63:0] offset;
    logic [63:0] cap;
    logic [ALOG_W-1:0] shift;
    logic same;
    logic old;
    int sel;
    int free_slot;
    r = '0;
    sel = -1;
    free_slot = -1;
    offset = '0;
    if (m == MODE_MARK) begin
      for (int i = 0; i < POOL_ENTRIES; i++)
        if (ent_present[i]) ent_avail[i] = 1'b1;
      return;
    end
    shift = (al < MIN_ALIGN_LOG2) ? MIN_ALIGN_LOG2 : al;
    step = 64'd1 << shift;
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      if (!ent_present[i]) begin
        if (free_slot < 0) free_slot = i;
      end else begin
        same = !ent_avail[i] && ent_frame[i] == fr;
        // plain compare, no wrap of the frame counter
        old = ent_avail[i] || (64'(ent_frame[i]) + 64'(fif_q) <= 64'(fr));
        if (same ? (round_to(64'(ent_fill[i]), step) + 64'(sz) <= 64'(ent_cap[i]))
                 : (old && 64'(sz) <= 64'(ent_cap[i]))) begin
          sel = i;
          break;
        end
      end
    end
    if (sel >= 0) begin
      if (ent_avail[sel] || ent_frame[sel] != fr) ent_fill[sel] = '0;
      offset = round_to(64'(ent_fill[sel]), step);
    end else if (free_slot < 0) begin
      r.status = STATUS_FULL;
      return;
    end else begin
      sel = free_slot;
      cap = round_to(64'(sz), MIB);
      if (cap < 64'(min_bytes_q)) cap = 64'(min_bytes_q);
      if (cap > 64'(CAP_MASK)) cap = 64'(CAP_MASK);
      ent_present[sel] = 1'b1;
      ent_cap[sel] = cap[CAP_W-1:0];
      offset = '0;
      r.newly_created = 1'b1;
    end
    ent_fill[sel] = CAP_W'(offset + 64'(sz));
    ent_frame[sel] = fr;
    ent_avail[sel] = 1'b0;
    r.status = STATUS_OK;
    r.buffer_index = BIDX_W'(sel);
    r.byte_offset = CAP_W'(offset);
  endtask

  always @(posedge clk) begin : track
    result_t want;
    result_t got;
    if (rst) begin
      fif_q = FIF_RESET;
      min_bytes_q = MIN_BYTES_RESET;
      for (int i = 0; i < POOL_ENTRIES; i++) begin
        ent_present[i] = 1'b0;
        ent_avail[i] = 1'b0;
      end
      grant_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_FRAMES_IN_FLIGHT) fif_q = cfg_data[FIF_W-1:0];
        else if (cfg_index == CFG_MIN_BUFFER_BYTES) min_bytes_q = cfg_data;
      end
      // results first: a result in the same cycle as an accept is always older
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          $error("result transfer with no grant expected");
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          got.status = status;
          got.buffer_index = buffer_index;
          got.byte_offset = byte_offset;
          got.newly_created = newly_created;
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.buffer_index !== want.buffer_index) begin
            $error("buffer_index: expected %0d, got %0d", want.buffer_index, got.buffer_index);
            fail_count++;
          end
          if (got.byte_offset !== want.byte_offset) begin
            $error("byte_offset: expected %0d, got %0d", want.byte_offset, got.byte_offset);
            fail_count++;
          end
          if (got.newly_created !== want.newly_created) begin
            $error("newly_created: expected %0d, got %0d", want.newly_created,
                   got.newly_created);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        serve_item(mode, frame_number, request_bytes, align_log2, want);
        if (want.status == STATUS_FULL) full_count++;
        if (want.newly_created) new_count++;
        grant_q.push_back(want);
      end
    end
    open_grants = grant_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the allocator testbench: clock, reset, register writes, request traffic and verdict.
`timescale 1ns / 100ps
module testbench;
  import fuba_pkg::*;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [CAP_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               mode;
  logic [FRAME_W-1:0] frame_number;
  logic [CAP_W-1:0]   request_bytes;
  logic [ALOG_W-1:0]  align_log2;
  logic               out_valid;
  logic               out_ready;
  logic               status;
  logic [BIDX_W-1:0]  buffer_index;
  logic [CAP_W-1:0]   byte_offset;
  logic               newly_created;

  int fail_count;
  int open_grants;
  int full_count;
  int new_count;
  int sent;
  int marks;
  int settings;
  int gap_weight;
  int stall_weight;
  bit calm;
  logic [FRAME_W-1:0] cur_frame;

  always #5 clk = ~clk;

  frame_upload_buffer_allocator uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .frame_number(frame_number), .request_bytes(request_bytes),
    .align_log2(align_log2),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .buffer_index(buffer_index), .byte_offset(byte_offset),
    .newly_created(newly_created)
  );

  pool_grant_checker chk (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .frame_number(frame_number), .request_bytes(request_bytes),
    .align_log2(align_log2),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .buffer_index(buffer_index), .byte_offset(byte_offset),
    .newly_created(newly_created),
    .fail_count(fail_count), .open_grants(open_grants),
    .full_count(full_count), .new_count(new_count)
  );

  initial begin : watchdog
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off to back the block up.
  initial begin : rx_side
    bit held_off;
    held_off = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && sent >= 400) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (250) @(negedge clk);
      end else if (calm || $urandom_range(0, 7) >= stall_weight) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic m, input logic [FRAME_W-1:0] fr,
                           input logic [CAP_W-1:0] sz, input logic [ALOG_W-1:0] al);
    if (!calm && $urandom_range(0, 7) < gap_weight) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    frame_number <= fr;
    request_bytes <= sz;
    align_log2 <= al;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (m == MODE_MARK) marks++;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [FIF_W-1:0] fif, input logic [CAP_W-1:0] min_b);
    cfg_write <= 1'b1;
    cfg_index <= CFG_FRAMES_IN_FLIGHT;
    cfg_data <= {27'($urandom), fif};  // upper bits are don't-care
    @(negedge clk);
    cfg_index <= CFG_MIN_BUFFER_BYTES;
    cfg_data <= min_b;
    @(negedge clk);
    cfg_write <= 1'b0;
    settings++;
  endtask

  task automatic drain(input int settle);
    in_valid <= 1'b0;
    while (open_grants != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic random_request();
    logic [FRAME_W-1:0] fr;
    logic [CAP_W-1:0] sz;
    logic [ALOG_W-1:0] al;
    int pick;
    if ($urandom_range(0, 99) < 8) begin
      send_item(MODE_MARK, $urandom, CAP_W'($urandom_range(0, 1 << 30)),
                ALOG_W'($urandom));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        fr = cur_frame;
      end else if (pick < 85) begin
        cur_frame = cur_frame + $urandom_range(1, 3);
        fr = cur_frame;
      end else if (pick < 92) begin
        fr = cur_frame - $urandom_range(1, 4);
      end else if (pick < 96) begin
        fr = $urandom;
      end else begin
        fr = 32'hFFFF_FFFF - $urandom_range(0, 3);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) sz = CAP_W'($urandom_range(0, 4095));
      else if (pick < 70) sz = CAP_W'($urandom_range(0, 1 << 20));
      else if (pick < 88) sz = CAP_W'($urandom_range(0, 8 << 20));
      else if (pick < 97) sz = CAP_W'($urandom_range(0, 1 << 30));
      else sz = $urandom_range(0, 1) ? CAP_W'(1 << 30) : '0;
      if ($urandom_range(0, 99) < 88) al = ALOG_W'($urandom_range(0, 16));
      else al = ALOG_W'($urandom_range(17, 31));
      send_item(MODE_ALLOC, fr, sz, al);
    end
  endtask

  initial begin : stimulus
    logic [FIF_W-1:0] fif;
    logic [CAP_W-1:0] min_b;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_FRAMES_IN_FLIGHT;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = MODE_ALLOC;
    frame_number = '0;
    request_bytes = '0;
    align_log2 = '0;
    gap_weight = 2;
    stall_weight = 2;
    calm = 1'b0;
    cur_frame = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Reset-value registers: fill a frame, then requests that only a new buffer can hold,
    // including a size that saturates the capacity and an oversized alignment.
    send_item(MODE_ALLOC, 32'd100, 31'd0, 5'd0);
    send_item(MODE_ALLOC, 32'd100, 31'd100, 5'd4);
    send_item(MODE_ALLOC, 32'd100, 31'd1000, 5'd8);
    send_item(MODE_ALLOC, 32'd100, 31'd1 << 30, 5'd16);
    send_item(MODE_ALLOC, 32'd100, 31'h7FFF_FFFF, 5'd31);
    send_item(MODE_ALLOC, 32'd100, 31'd16, 5'd31);
    drain(4);

    // Frame behind every last use, zero minimum: a zero-capacity buffer appears.
    set_config(4'd15, '0);
    send_item(MODE_ALLOC, 32'd99, 31'd0, 5'd0);
    send_item(MODE_ALLOC, 32'd99, 31'd0, 5'd16);
    send_item(MODE_ALLOC, 32'd99, 31'd1, 5'd0);
    drain(4);

    // No frames in flight: anything not ahead of the frame is retired, if large enough.
    set_config(4'd0, 31'd1 << 30);
    send_item(MODE_ALLOC, 32'd101, 31'd5 << 20, 5'd0);
    send_item(MODE_ALLOC, 32'd101, 31'd7, 5'd3);
    drain(4);

    // Fill the last two slots, run out, then release everything.
    set_config(4'd8, 31'd1 << 30);
    send_item(MODE_ALLOC, 32'd99, 31'd1 << 30, 5'd0);
    send_item(MODE_ALLOC, 32'd99, 31'd1 << 30, 5'd0);
    send_item(MODE_ALLOC, 32'd99, 31'd1 << 30, 5'd0);
    send_item(MODE_ALLOC, 32'd99, 31'd16, 5'd4);
    send_item(MODE_MARK, 32'hFFFF_FFFF, 31'd1 << 30, 5'd31);
    send_item(MODE_ALLOC, 32'd50, 31'd5000, 5'd5);
    send_item(MODE_ALLOC, 32'd50, 31'd5000, 5'd5);
    send_item(MODE_ALLOC, 32'hFFFF_FFFF, 31'd1, 5'd0);
    send_item(MODE_ALLOC, 32'd0, 31'd1 << 30, 5'd0);
    drain(4);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin fif = 4'd1;  min_b = 31'd1 << 20; end
        1: begin fif = 4'd8;  min_b = 31'd1 << 30; end
        2: begin fif = FIF_RESET; min_b = MIN_BYTES_RESET; end
        3: begin fif = 4'd0;  min_b = '0; end
        4: begin fif = 4'd15; min_b = CAP_MASK; end
        default: begin
          fif = FIF_W'($urandom_range(1, 8));
          min_b = CAP_W'($urandom_range(1 << 20, 1 << 26));
        end
      endcase
      set_config(fif, min_b);
      gap_weight = p % 4;
      stall_weight = (p * 3) % 4;
      calm = (p == 7);
      cur_frame = (p == 4) ? 32'hFFFF_FF80 : FRAME_W'($urandom_range(0, 100000));
      repeat (119) random_request();
      drain(4);
    end

    drain(40);
    $display("covered %0d requests (%0d marks) over %0d register settings", sent, marks,
             settings);
    $display("pool ran out %0d times, %0d buffers were created", full_count, new_count);
    if (fail_count == 0 && open_grants == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
